/* sv/ir_pulse_distance_frame_encoder_assert.svh */
// assertion macros for the pulse distance frame encoder
`ifndef IR_PULSE_DISTANCE_FRAME_ENCODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_ENCODER_ASSERT_SVH

// implication or plain property checked on every clock edge out of reset
`define IRPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define IRPD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* sv/irpd_pkg.sv */
package irpd_pkg;

	localparam int TICK_W     = 15;
	localparam int PAIR_W     = 30;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int ITEM_IDX_W = 6;

	localparam logic [ITEM_IDX_W-1:0] IDX_LEADER  = 6'd0;
	localparam logic [ITEM_IDX_W-1:0] IDX_TRAILER = 6'd49;
	localparam logic [ITEM_IDX_W-1:0] IDX_TERM    = 6'd50;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_LEADER  = 3'd1,
		REG_ZERO    = 3'd2,
		REG_ONE     = 3'd3,
		REG_TRAILER = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              inverse;
		logic              extended;
		logic [PAIR_W-1:0] leader_ticks;
		logic [PAIR_W-1:0] zero_ticks;
		logic [PAIR_W-1:0] one_ticks;
		logic [PAIR_W-1:0] trailer_ticks;
	} cfg_t;

endpackage

/* sv/irpd_regs.sv */
module irpd_regs
	import irpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE: begin
					cfg_q.inverse  <= pwdata[0];
					cfg_q.extended <= pwdata[1];
				end
				REG_LEADER:  cfg_q.leader_ticks  <= pwdata[PAIR_W-1:0];
				REG_ZERO:    cfg_q.zero_ticks    <= pwdata[PAIR_W-1:0];
				REG_ONE:     cfg_q.one_ticks     <= pwdata[PAIR_W-1:0];
				REG_TRAILER: cfg_q.trailer_ticks <= pwdata[PAIR_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux, unmapped addresses read zero
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MODE:    prdata = {{(APB_DATA_W-2){1'b0}}, cfg_q.extended, cfg_q.inverse};
			REG_LEADER:  prdata = {{(APB_DATA_W-PAIR_W){1'b0}}, cfg_q.leader_ticks};
			REG_ZERO:    prdata = {{(APB_DATA_W-PAIR_W){1'b0}}, cfg_q.zero_ticks};
			REG_ONE:     prdata = {{(APB_DATA_W-PAIR_W){1'b0}}, cfg_q.one_ticks};
			REG_TRAILER: prdata = {{(APB_DATA_W-PAIR_W){1'b0}}, cfg_q.trailer_ticks};
			default:     prdata = '0;
		endcase
	end

endmodule

/* sv/ir_pulse_distance_frame_encoder.sv */
// Pulse distance infrared frame encoder. One transfer on the item channel
// (16-bit address, 32-bit command) becomes 51 pulse transfers on the pulse
// channel: a leader, 48 data symbols (address then command, lsb first), an
// end mark and an all-zero terminator flagged last_item. Mark and space tick
// counts per symbol come from the registers at byte addresses 0x00 (mode),
// 0x04 (leader), 0x08 (zero), 0x0c (one) and 0x10 (trailer); each packs the
// mark in bits 14:0 and the space in bits 29:15. Mode bit 0 swaps the levels,
// mode bit 1 turns off the byte/complement checks; with it clear, a frame
// that fails a check yields one transfer with bad_frame and last_item set.
// One pulse leaves the output register per cycle while pulse_ready is
// high. The next item is taken in the same cycle its predecessor's last
// pulse enters the output register, so frames stream with no gap. The
// user must write registers only while the block is idle; the block
// itself does not enforce it.
module ir_pulse_distance_frame_encoder
	import irpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// item channel
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [15:0]           address,
	input  logic [31:0]           command,
	// pulse channel
	output logic                  pulse_valid,
	input  logic                  pulse_ready,
	output logic                  first_level,
	output logic [TICK_W-1:0]     first_ticks,
	output logic                  second_level,
	output logic [TICK_W-1:0]     second_ticks,
	output logic                  bad_frame,
	output logic                  last_item
);

`include "ir_pulse_distance_frame_encoder_assert.svh"

	cfg_t cfg;

	irpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// frame state: payload shifts right once per data symbol
	logic                  busy_q;
	logic                  bad_q;
	logic [ITEM_IDX_W-1:0] idx_q;
	logic [47:0]           payload_q;

	// output register
	logic              out_valid_q;
	logic              first_level_q;
	logic [TICK_W-1:0] first_ticks_q;
	logic              second_level_q;
	logic [TICK_W-1:0] second_ticks_q;
	logic              bad_frame_q;
	logic              last_item_q;

	logic              item_fire;
	logic              gen_fire;
	logic              gen_last;
	logic              check_fail;
	logic              is_data;
	logic [PAIR_W-1:0] sym;

	logic              nx_first_level;
	logic [TICK_W-1:0] nx_first_ticks;
	logic              nx_second_level;
	logic [TICK_W-1:0] nx_second_ticks;
	logic              nx_bad_frame;
	logic              nx_last_item;

	// each byte pair must be a byte followed by its complement
	assign check_fail = !cfg.extended &&
		((address[7:0]   != (~address[15:8]  & BYTE_MASK)) ||
		 (command[23:16] != (~command[31:24] & BYTE_MASK)) ||
		 (command[7:0]   != (~command[15:8]  & BYTE_MASK)));

	// one pulse per cycle whenever the output register is free or drains
	assign gen_fire   = busy_q && (!out_valid_q || pulse_ready);
	assign gen_last   = bad_q || (idx_q == IDX_TERM);
	assign item_ready = !busy_q || (gen_fire && gen_last);
	assign item_fire  = item_valid && item_ready;
	assign is_data    = (idx_q != IDX_LEADER) && (idx_q < IDX_TRAILER);

	// symbol selection for the current pulse
	always_comb begin
		sym             = '0;
		nx_first_level  = !cfg.inverse;
		nx_second_level = cfg.inverse;
		nx_bad_frame    = 1'b0;
		nx_last_item    = 1'b0;
		case (idx_q)
			IDX_LEADER:  sym = cfg.leader_ticks;
			IDX_TRAILER: sym = cfg.trailer_ticks;
			IDX_TERM: begin
				// terminator is all zero whatever the level mode
				nx_first_level  = 1'b0;
				nx_second_level = 1'b0;
				nx_last_item    = 1'b1;
			end
			default:     sym = payload_q[0] ? cfg.one_ticks : cfg.zero_ticks;
		endcase
		if (bad_q) begin
			sym             = '0;
			nx_first_level  = 1'b0;
			nx_second_level = 1'b0;
			nx_bad_frame    = 1'b1;
			nx_last_item    = 1'b1;
		end
		nx_first_ticks  = sym[TICK_W-1:0];
		nx_second_ticks = sym[PAIR_W-1:TICK_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bad_q  <= 1'b0;
			idx_q  <= '0;
		end else if (item_fire) begin
			busy_q <= 1'b1;
			bad_q  <= check_fail;
			idx_q  <= IDX_LEADER;
		end else if (gen_fire) begin
			if (gen_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			payload_q <= {command, address};
		end else if (gen_fire && is_data) begin
			payload_q <= {1'b0, payload_q[47:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (gen_fire) begin
			out_valid_q <= 1'b1;
		end else if (pulse_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			first_level_q  <= nx_first_level;
			first_ticks_q  <= nx_first_ticks;
			second_level_q <= nx_second_level;
			second_ticks_q <= nx_second_ticks;
			bad_frame_q    <= nx_bad_frame;
			last_item_q    <= nx_last_item;
		end
	end

	assign pulse_valid  = out_valid_q;
	assign first_level  = first_level_q;
	assign first_ticks  = first_ticks_q;
	assign second_level = second_level_q;
	assign second_ticks = second_ticks_q;
	assign bad_frame    = bad_frame_q;
	assign last_item    = last_item_q;

	`IRPD_ASSERT(a_bad_is_last, (pulse_valid && bad_frame) |-> last_item, "error pulse not last")
	`IRPD_ASSERT(a_term_zero, (pulse_valid && last_item && !bad_frame) |-> (first_ticks == '0 && second_ticks == '0 && !first_level && !second_level), "terminator not all zero")
	`IRPD_ASSERT(a_idle_after_last, (gen_fire && gen_last && !item_fire) |=> !busy_q, "frame state busy after terminator")
	`IRPD_ASSERT_NEVER(a_idx_range, busy_q && (idx_q > IDX_TERM), "pulse index past terminator")

endmodule
